// ----- design/assert_macros.svh -----
// Assertion wrappers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ESC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ESC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("reset assertion failed");
`else
`define ESC_ASSERT(lbl, prop)
`define ESC_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- design/esc_pkg.sv -----
`timescale 1ns / 1ps
package esc_pkg;

  localparam int DIV_W     = 64;
  localparam int DIV_STEPS = 64;
  localparam int FRONT_LAT = 5;
  localparam int PRS_LAT   = 80;
  localparam int HUM_LAT   = 11;
  localparam int PIPE_LAT  = FRONT_LAT + PRS_LAT;

  localparam logic [63:0] PRS_TF_OFS = 64'd128000;
  localparam logic [63:0] PRS_P_OFS  = 64'd1048576;
  localparam logic [63:0] PRS_NUM_K  = 64'd3125;
  localparam logic [63:0] PRS_AX_OFS = 64'h0000_8000_0000_0000;
  localparam logic [31:0] HUM_TF_OFS = 32'd76800;
  localparam logic [31:0] HUM_MAX_Q  = 32'd419430400;
  localparam logic [31:0] HUM_Y_OFS  = 32'd2097152;
  localparam logic [31:0] HUM_X_RND  = 32'd16384;
  localparam logic [31:0] HUM_Y2_OFS = 32'd32768;
  localparam logic [31:0] HUM_Y_RND  = 32'd8192;
  localparam logic [31:0] TMP_RND    = 32'd128;
  localparam logic [16:0] HUM_MAX    = 17'd102400;

  typedef enum logic [2:0] {
    CFG_TEMP     = 3'd0,
    CFG_PRESS_LO = 3'd1,
    CFG_PRESS_HI = 3'd2,
    CFG_MIXED    = 3'd3,
    CFG_HUM      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [7:0]  h6;
  } cal_t;

  function automatic logic [31:0] sx16_32(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sx8_32(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

  function automatic logic [63:0] sx16_64(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    return 64'($signed(x) >>> n);
  endfunction

endpackage

// ----- design/esc_dly.sv -----
`timescale 1ns / 1ps
module esc_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        sr_r[k] <= sr_r[k-1];
      end
    end
  end

  assign q_o = sr_r[N-1];
endmodule

// ----- design/esc_mul64.sv -----
`timescale 1ns / 1ps
// 64x64 -> low 64 bits, two stages
module esc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] ll_r;
  logic [31:0] lh_r;
  logic [31:0] hl_r;
  logic [63:0] p_r;
  logic [31:0] cross_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
      lh_r <= a_i[31:0] * b_i[63:32];
      hl_r <= a_i[63:32] * b_i[31:0];
    end
  end

  assign cross_nxt = lh_r + hl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= ll_r + {cross_nxt, 32'd0};
    end
  end

  assign p_o = p_r;
endmodule

// ----- design/esc_div.sv -----
`timescale 1ns / 1ps
// unsigned restoring divider, one quotient bit per stage
module esc_div #(
  parameter int TAG_W = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [63:0]      dvd_i,
  input  logic [63:0]      den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic [63:0]      quo_o,
  output logic [TAG_W-1:0] tag_o
);
  import esc_pkg::*;

  logic [DIV_W-1:0] rem_r [1:DIV_STEPS-1];
  logic [DIV_W-1:0] den_r [1:DIV_STEPS-1];
  logic [DIV_W-1:0] dvd_r [1:DIV_STEPS];
  logic [TAG_W-1:0] tag_r [1:DIV_STEPS];

  logic [DIV_W-1:0] rem_s [DIV_STEPS];
  logic [DIV_W-1:0] den_s [DIV_STEPS];
  logic [DIV_W-1:0] dvd_s [DIV_STEPS];
  logic [TAG_W-1:0] tag_s [DIV_STEPS];
  logic [DIV_W:0]   trial_c [DIV_STEPS];
  logic [DIV_W:0]   diff_c [DIV_STEPS];

  always_comb begin
    rem_s[0] = '0;
    den_s[0] = den_i;
    dvd_s[0] = dvd_i;
    tag_s[0] = tag_i;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_s[k] = rem_r[k];
      den_s[k] = den_r[k];
      dvd_s[k] = dvd_r[k];
      tag_s[k] = tag_r[k];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial_c[k] = {rem_s[k], dvd_s[k][DIV_W-1]};
      diff_c[k]  = trial_c[k] - {1'b0, den_s[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS - 1; k++) begin
        rem_r[k+1] <= diff_c[k][DIV_W] ? trial_c[k][DIV_W-1:0] : diff_c[k][DIV_W-1:0];
        den_r[k+1] <= den_s[k];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        dvd_r[k+1] <= {dvd_s[k][DIV_W-2:0], ~diff_c[k][DIV_W]};
        tag_r[k+1] <= tag_s[k];
      end
    end
  end

  assign quo_o = dvd_r[DIV_STEPS];
  assign tag_o = tag_r[DIV_STEPS];
endmodule

// ----- design/esc_temp.sv -----
`timescale 1ns / 1ps
module esc_temp (
  input  logic          clk,
  input  logic          en,
  input  esc_pkg::cal_t cal,
  input  logic [15:0]   temp_adc,
  input  logic [15:0]   press_adc,
  input  logic [15:0]   hum_adc,
  output logic [23:0]   tc_o,
  output logic [63:0]   a_o,
  output logic [31:0]   v_o,
  output logic [19:0]   adcp_o,
  output logic [15:0]   adch_o
);
  import esc_pkg::*;

  logic [31:0] adc_t;
  logic [31:0] t1x;
  logic [31:0] d1_r, d2_r, m1_r, m2_r, va_r, m3_r, tf_r;
  logic [19:0] adcp1_r, adcp2_r, adcp3_r, adcp4_r, adcp5_r;
  logic [15:0] adch1_r, adch2_r, adch3_r, adch4_r, adch5_r;
  logic [31:0] tc_nxt;
  logic [23:0] tc_r;
  logic [63:0] a_r;
  logic [31:0] v_r;

  assign adc_t  = {12'd0, temp_adc, 4'd0};
  assign t1x    = {16'd0, cal.t1};
  assign tc_nxt = asr32((tf_r << 2) + tf_r + TMP_RND, 8);

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r    <= (adc_t >> 3) - (t1x << 1);
      d2_r    <= (adc_t >> 4) - t1x;
      adcp1_r <= {press_adc, 4'd0};
      adch1_r <= hum_adc;
      m1_r    <= d1_r * sx16_32(cal.t2);
      m2_r    <= d2_r * d2_r;
      adcp2_r <= adcp1_r;
      adch2_r <= adch1_r;
      va_r    <= asr32(m1_r, 11);
      m3_r    <= asr32(m2_r, 12) * sx16_32(cal.t3);
      adcp3_r <= adcp2_r;
      adch3_r <= adch2_r;
      tf_r    <= va_r + asr32(m3_r, 14);
      adcp4_r <= adcp3_r;
      adch4_r <= adch3_r;
      tc_r    <= tc_nxt[23:0];
      a_r     <= {{32{tf_r[31]}}, tf_r} - PRS_TF_OFS;
      v_r     <= tf_r - HUM_TF_OFS;
      adcp5_r <= adcp4_r;
      adch5_r <= adch4_r;
    end
  end

  assign tc_o   = tc_r;
  assign a_o    = a_r;
  assign v_o    = v_r;
  assign adcp_o = adcp5_r;
  assign adch_o = adch5_r;
endmodule

// ----- design/esc_hum.sv -----
`timescale 1ns / 1ps
module esc_hum (
  input  logic          clk,
  input  logic          en,
  input  esc_pkg::cal_t cal,
  input  logic [31:0]   v_i,
  input  logic [15:0]   adch_i,
  output logic [16:0]   hum_o
);
  import esc_pkg::*;

  logic [31:0] mh5_r, y1m_r, y2m_r, xpre_r;
  logic [31:0] x_r, y1_r, y2_r;
  logic [31:0] mc_r, xc_r, t_r, xd_r, me_r, xe_r, y_r, xf_r;
  logic [31:0] hx_r, s_r, hxh_r, ss_r, hxi_r, mj_r, hxj_r;
  logic [31:0] hx_nxt;
  logic [31:0] hxc_nxt;
  logic [16:0] hum_r;

  always_comb begin
    hx_nxt = hxj_r - asr32(mj_r, 4);
    if (hx_nxt[31]) begin
      hxc_nxt = '0;
    end else if (hx_nxt > HUM_MAX_Q) begin
      hxc_nxt = HUM_MAX_Q;
    end else begin
      hxc_nxt = hx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mh5_r  <= sx16_32(cal.h5) * v_i;
      y1m_r  <= v_i * sx8_32(cal.h6);
      y2m_r  <= v_i * {24'd0, cal.h3};
      xpre_r <= ({16'd0, adch_i} << 14) - (sx16_32(cal.h4) << 20) + HUM_X_RND;
      x_r    <= asr32(xpre_r - mh5_r, 15);
      y1_r   <= asr32(y1m_r, 10);
      y2_r   <= asr32(y2m_r, 11) + HUM_Y2_OFS;
      mc_r   <= y1_r * y2_r;
      xc_r   <= x_r;
      t_r    <= asr32(mc_r, 10) + HUM_Y_OFS;
      xd_r   <= xc_r;
      me_r   <= t_r * sx16_32(cal.h2);
      xe_r   <= xd_r;
      y_r    <= asr32(me_r + HUM_Y_RND, 14);
      xf_r   <= xe_r;
      hx_r   <= xf_r * y_r;
      s_r    <= asr32(hx_r, 15);
      hxh_r  <= hx_r;
      ss_r   <= s_r * s_r;
      hxi_r  <= hxh_r;
      mj_r   <= asr32(ss_r, 7) * {24'd0, cal.h1};
      hxj_r  <= hxi_r;
      hum_r  <= hxc_nxt[28:12];
    end
  end

  assign hum_o = hum_r;
endmodule

// ----- design/esc_prs.sv -----
`timescale 1ns / 1ps
module esc_prs (
  input  logic          clk,
  input  logic          en,
  input  esc_pkg::cal_t cal,
  input  logic [63:0]   a_i,
  input  logic [19:0]   adcp_i,
  output logic [31:0]   pres_o,
  output logic          pvalid_o
);
  import esc_pkg::*;

  logic [63:0] p0s_c, p0s_d;
  logic [63:0] aa, ap5, ap2, aap6, aap3, ap5_d, ap2_d;
  logic [63:0] b_r, ax_r, diff_r, ax2_r;
  logic [63:0] a3raw, numraw, a3_c, mn_c, md_c;
  logic [63:0] mn_r, md_r;
  logic [1:0]  dtag_r, qtag;
  logic [63:0] qa, q_r, qq_c, qq_d, q_d, m9, c2m, c2_d, c1m, sum_r, pfin;
  logic        dz_r, dz_d;
  logic [31:0] pres_r;
  logic        pvalid_r;

  assign p0s_c = (PRS_P_OFS - {44'd0, adcp_i}) << 31;

  esc_dly #(.W(64), .N(5)) u_p0s (.clk, .en, .d_i(p0s_c), .q_o(p0s_d));

  esc_mul64 u_aa  (.clk, .en, .a_i(a_i), .b_i(a_i), .p_o(aa));
  esc_mul64 u_ap5 (.clk, .en, .a_i(a_i), .b_i(sx16_64(cal.p5)), .p_o(ap5));
  esc_mul64 u_ap2 (.clk, .en, .a_i(a_i), .b_i(sx16_64(cal.p2)), .p_o(ap2));
  esc_mul64 u_aap6 (.clk, .en, .a_i(aa), .b_i(sx16_64(cal.p6)), .p_o(aap6));
  esc_mul64 u_aap3 (.clk, .en, .a_i(aa), .b_i(sx16_64(cal.p3)), .p_o(aap3));
  esc_dly #(.W(64), .N(2)) u_ap5d (.clk, .en, .d_i(ap5), .q_o(ap5_d));
  esc_dly #(.W(64), .N(2)) u_ap2d (.clk, .en, .d_i(ap2), .q_o(ap2_d));

  always_ff @(posedge clk) begin
    if (en) begin
      b_r    <= aap6 + (ap5_d << 17) + (sx16_64(cal.p4) << 35);
      ax_r   <= PRS_AX_OFS + asr64(aap3, 8) + (ap2_d << 12);
      diff_r <= p0s_d - b_r;
      ax2_r  <= ax_r;
    end
  end

  esc_mul64 u_a3  (.clk, .en, .a_i(ax2_r), .b_i({48'd0, cal.p1}), .p_o(a3raw));
  esc_mul64 u_num (.clk, .en, .a_i(diff_r), .b_i(PRS_NUM_K), .p_o(numraw));

  assign a3_c = asr64(a3raw, 33);
  assign mn_c = numraw[63] ? (64'd0 - numraw) : numraw;
  assign md_c = a3_c[63] ? (64'd0 - a3_c) : a3_c;

  always_ff @(posedge clk) begin
    if (en) begin
      mn_r   <= mn_c;
      md_r   <= md_c;
      dtag_r <= {numraw[63] ^ a3_c[63], a3_c == 64'd0};
    end
  end

  esc_div #(.TAG_W(2)) u_div (
    .clk, .en, .dvd_i(mn_r), .den_i(md_r), .tag_i(dtag_r), .quo_o(qa), .tag_o(qtag)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      q_r  <= qtag[1] ? (64'd0 - qa) : qa;
      dz_r <= qtag[0];
    end
  end

  assign qq_c = asr64(q_r, 13);

  esc_mul64 u_m9 (.clk, .en, .a_i(sx16_64(cal.p9)), .b_i(qq_c), .p_o(m9));
  esc_mul64 u_c2 (.clk, .en, .a_i(sx16_64(cal.p8)), .b_i(q_r), .p_o(c2m));
  esc_dly #(.W(64), .N(2)) u_qqd (.clk, .en, .d_i(qq_c), .q_o(qq_d));
  esc_dly #(.W(64), .N(4)) u_qd  (.clk, .en, .d_i(q_r), .q_o(q_d));
  esc_dly #(.W(1),  .N(5)) u_dzd (.clk, .en, .d_i(dz_r), .q_o(dz_d));
  esc_dly #(.W(64), .N(2)) u_c2d (.clk, .en, .d_i(c2m), .q_o(c2_d));
  esc_mul64 u_c1 (.clk, .en, .a_i(m9), .b_i(qq_d), .p_o(c1m));

  assign pfin = asr64(sum_r, 8) + (sx16_64(cal.p7) << 4);

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= q_d + asr64(c1m, 25) + asr64(c2_d, 19);
      if (dz_d) begin
        pres_r   <= '0;
        pvalid_r <= 1'b0;
      end else begin
        pvalid_r <= 1'b1;
        if (pfin[63]) begin
          pres_r <= '0;
        end else if (pfin[62:32] != '0) begin
          pres_r <= '1;
        end else begin
          pres_r <= pfin[31:0];
        end
      end
    end
  end

  assign pres_o   = pres_r;
  assign pvalid_o = pvalid_r;
endmodule

// ----- design/environmental_sensor_compensation_core.sv -----
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// in_     | request   | in_valid/in_stall  | temp_adc, press_adc, hum_adc
// out_    | result    | out_valid/out_stall| temperature, pressure, pressure_valid, humidity
// cfg_    | write     | cfg_we             | cfg_index, cfg_wdata
//
// One request per cycle unless out_stall holds a waiting result; 85 register stages
// carry a request from the edge that takes it to its valid result.
// Latency is set by the 64-stage pressure divider plus the multiplier stages around it.
// The whole pipe advances together; in_stall is high only while a result waits stalled.
// Reset (rst_n low, synchronous) clears the valid bits and calibration registers.
module environmental_sensor_compensation_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_temp_adc,
  input  logic [15:0]        in_press_adc,
  input  logic [15:0]        in_hum_adc,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_temperature,
  output logic [31:0]        out_pressure,
  output logic               out_pressure_valid,
  output logic [16:0]        out_humidity,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);
  import esc_pkg::*;
  `include "assert_macros.svh"

  logic [47:0] temp_cal_r;
  logic [63:0] press_lo_r;
  logic [63:0] press_hi_r;
  logic [47:0] mixed_cal_r;
  logic [39:0] hum_cal_r;
  cal_t        cal;
  logic        adv;
  logic [PIPE_LAT-1:0] vld_r;
  logic [23:0] tc_f, tc_d;
  logic [63:0] a_f;
  logic [31:0] v_f;
  logic [19:0] adcp_f;
  logic [15:0] adch_f;
  logic [16:0] hum_h, hum_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r  <= '0;
      press_lo_r  <= '0;
      press_hi_r  <= '0;
      mixed_cal_r <= '0;
      hum_cal_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEMP:     temp_cal_r  <= cfg_wdata[47:0];
        CFG_PRESS_LO: press_lo_r  <= cfg_wdata;
        CFG_PRESS_HI: press_hi_r  <= cfg_wdata;
        CFG_MIXED:    mixed_cal_r <= cfg_wdata[47:0];
        CFG_HUM:      hum_cal_r   <= cfg_wdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = temp_cal_r[15:0];
    cal.t2 = temp_cal_r[31:16];
    cal.t3 = temp_cal_r[47:32];
    cal.p1 = press_lo_r[15:0];
    cal.p2 = press_lo_r[31:16];
    cal.p3 = press_lo_r[47:32];
    cal.p4 = press_lo_r[63:48];
    cal.p5 = press_hi_r[15:0];
    cal.p6 = press_hi_r[31:16];
    cal.p7 = press_hi_r[47:32];
    cal.p8 = press_hi_r[63:48];
    cal.p9 = mixed_cal_r[15:0];
    cal.h1 = mixed_cal_r[23:16];
    cal.h2 = mixed_cal_r[39:24];
    cal.h3 = mixed_cal_r[47:40];
    cal.h4 = hum_cal_r[15:0];
    cal.h5 = hum_cal_r[31:16];
    cal.h6 = hum_cal_r[39:32];
  end

  assign adv      = !vld_r[PIPE_LAT-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  esc_temp u_temp (
    .clk, .en(adv), .cal,
    .temp_adc(in_temp_adc), .press_adc(in_press_adc), .hum_adc(in_hum_adc),
    .tc_o(tc_f), .a_o(a_f), .v_o(v_f), .adcp_o(adcp_f), .adch_o(adch_f)
  );

  esc_prs u_prs (
    .clk, .en(adv), .cal, .a_i(a_f), .adcp_i(adcp_f),
    .pres_o(out_pressure), .pvalid_o(out_pressure_valid)
  );

  esc_hum u_hum (
    .clk, .en(adv), .cal, .v_i(v_f), .adch_i(adch_f), .hum_o(hum_h)
  );

  esc_dly #(.W(24), .N(PRS_LAT)) u_tcd (.clk, .en(adv), .d_i(tc_f), .q_o(tc_d));
  esc_dly #(.W(17), .N(PRS_LAT - HUM_LAT)) u_hmd (
    .clk, .en(adv), .d_i(hum_h), .q_o(hum_d)
  );

  assign out_valid       = vld_r[PIPE_LAT-1];
  assign out_temperature = $signed(tc_d);
  assign out_humidity    = hum_d;

  `ESC_ASSERT(a_pres_zero, out_valid && !out_pressure_valid |-> out_pressure == 32'd0)
  `ESC_ASSERT(a_hum_range, out_valid |-> out_humidity <= HUM_MAX)
  `ESC_ASSERT(a_stall_hold, !adv |=> $stable(vld_r))
  `ESC_ASSERT_RST(a_rst_clear, !rst_n |=> !out_valid)
endmodule

// ----- tb/sv/tb_environmental_sensor_compensation_core.sv -----
`timescale 1ns / 1ps
module tb_environmental_sensor_compensation_core;
  import esc_pkg::*;

  typedef struct {
    logic [15:0] temp;
    logic [15:0] press;
    logic [15:0] hum;
  } sample_t;

  typedef struct {
    logic [23:0] temp;
    logic [31:0] press;
    logic        press_ok;
    logic [16:0] hum;
  } reading_t;

  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_temp_adc = '0;
  logic [15:0] in_press_adc = '0;
  logic [15:0] in_hum_adc = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] out_temperature;
  logic [31:0] out_pressure;
  logic out_pressure_valid;
  logic [16:0] out_humidity;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  environmental_sensor_compensation_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // calibration copy
  logic [47:0] temp_cal = '0;
  logic [63:0] press_lo = '0;
  logic [63:0] press_hi = '0;
  logic [47:0] mixed_cal = '0;
  logic [39:0] hum_cal = '0;

  sample_t  pending[$];
  reading_t readings_due[$];
  sample_t  cur_req;
  bit holding = 0;
  bit hold_off = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;

  function automatic logic [31:0] sr32(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] sr64(input logic [63:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic reading_t compensate(input sample_t s);
    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] adc_t, adc_h, d1, d2, va, vb, tf, tc, v, x, y1, y2, y, hx, hs;
    logic [63:0] adc_p, a, b, p, num, mn, md, q, c1, c2;
    reading_t r;
    t1 = {16'b0, temp_cal[15:0]};
    t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
    t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
    p1 = {48'b0, press_lo[15:0]};
    p2 = {{48{press_lo[31]}}, press_lo[31:16]};
    p3 = {{48{press_lo[47]}}, press_lo[47:32]};
    p4 = {{48{press_lo[63]}}, press_lo[63:48]};
    p5 = {{48{press_hi[15]}}, press_hi[15:0]};
    p6 = {{48{press_hi[31]}}, press_hi[31:16]};
    p7 = {{48{press_hi[47]}}, press_hi[47:32]};
    p8 = {{48{press_hi[63]}}, press_hi[63:48]};
    p9 = {{48{mixed_cal[15]}}, mixed_cal[15:0]};
    h1 = {24'b0, mixed_cal[23:16]};
    h2 = {{16{mixed_cal[39]}}, mixed_cal[39:24]};
    h3 = {24'b0, mixed_cal[47:40]};
    h4 = {{16{hum_cal[15]}}, hum_cal[15:0]};
    h5 = {{16{hum_cal[31]}}, hum_cal[31:16]};
    h6 = {{24{hum_cal[39]}}, hum_cal[39:32]};
    adc_t = {12'b0, s.temp, 4'b0};
    adc_p = {44'b0, s.press, 4'b0};
    adc_h = {16'b0, s.hum};

    d1 = sr32(adc_t, 3) - (t1 << 1);
    va = sr32(d1 * t2, 11);
    d2 = sr32(adc_t, 4) - t1;
    vb = sr32(sr32(d2 * d2, 12) * t3, 14);
    tf = va + vb;
    tc = sr32(tf * 32'd5 + TMP_RND, 8);
    r.temp = tc[23:0];

    a = {{32{tf[31]}}, tf} - PRS_TF_OFS;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = sr64(a * a * p3, 8) + ((a * p2) << 12);
    a = sr64((PRS_AX_OFS + a) * p1, 33);
    r.press = '0;
    r.press_ok = 1'b0;
    if (a != 0) begin
      p = PRS_P_OFS - adc_p;
      num = ((p << 31) - b) * PRS_NUM_K;
      mn = num[63] ? -num : num;
      md = a[63] ? -a : a;
      q = mn / md;
      p = (num[63] != a[63]) ? -q : q;
      q = sr64(p, 13);
      c1 = sr64(p9 * q * q, 25);
      c2 = sr64(p8 * p, 19);
      p = sr64(p + c1 + c2, 8) + (p7 << 4);
      if (p[63]) r.press = '0;
      else if (p > 64'hFFFF_FFFF) r.press = 32'hFFFF_FFFF;
      else r.press = p[31:0];
      r.press_ok = 1'b1;
    end

    v = tf - HUM_TF_OFS;
    x = sr32((adc_h << 14) - (h4 << 20) - h5 * v + HUM_X_RND, 15);
    y1 = sr32(v * h6, 10);
    y2 = sr32(v * h3, 11) + HUM_Y2_OFS;
    y = sr32((sr32(y1 * y2, 10) + HUM_Y_OFS) * h2 + HUM_Y_RND, 14);
    hx = x * y;
    hs = sr32(hx, 15);
    hx = hx - sr32(sr32(hs * hs, 7) * h1, 4);
    if (hx[31]) hx = '0;
    else if (hx > HUM_MAX_Q) hx = HUM_MAX_Q;
    r.hum = hx[28:12];
    return r;
  endfunction

  // request side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      holding = 0;
    end else begin
      if (in_valid && !in_stall) begin
        readings_due.push_back(compensate(cur_req));
        holding = 0;
      end
      if (!holding) begin
        if (pending.size() > 0 && !hold_off && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending.pop_front();
          in_temp_adc <= cur_req.temp;
          in_press_adc <= cur_req.press;
          in_hum_adc <= cur_req.hum;
          in_valid <= 1'b1;
          holding = 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    reading_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result t=%h p=%h pv=%b h=%h", $time, out_temperature,
                   out_pressure, out_pressure_valid, out_humidity);
          errors++;
        end else begin
          e = readings_due.pop_front();
          if (out_temperature !== e.temp) begin
            $display("%0t: temperature exp %h got %h", $time, e.temp, out_temperature);
            errors++;
          end
          if (out_pressure !== e.press) begin
            $display("%0t: pressure exp %h got %h", $time, e.press, out_pressure);
            errors++;
          end
          if (out_pressure_valid !== e.press_ok) begin
            $display("%0t: pressure_valid exp %b got %b", $time, e.press_ok,
                     out_pressure_valid);
            errors++;
          end
          if (out_humidity !== e.hum) begin
            $display("%0t: humidity exp %h got %h", $time, e.hum, out_humidity);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_cal(input logic [2:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TEMP: temp_cal = data[47:0];
      CFG_PRESS_LO: press_lo = data;
      CFG_PRESS_HI: press_hi = data;
      CFG_MIXED: mixed_cal = data[47:0];
      CFG_HUM: hum_cal = data[39:0];
      default: ;
    endcase
  endtask

  task automatic load_cal(input logic [47:0] tc, input logic [63:0] pl,
                          input logic [63:0] ph, input logic [47:0] mc, input logic [39:0] hc);
    write_cal(CFG_TEMP, {$urandom, $urandom} & ~64'hFFFF_0000_0000_0000 | {16'b0, tc});
    write_cal(CFG_TEMP, {16'b0, tc});
    write_cal(CFG_PRESS_LO, pl);
    write_cal(CFG_PRESS_HI, ph);
    write_cal(CFG_MIXED, {16'b0, mc});
    write_cal(CFG_HUM, {24'b0, hc});
  endtask

  function automatic logic [15:0] rand_raw();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h4000 + 16'($urandom_range(16'h7FFF));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_sample(input logic [15:0] t, input logic [15:0] p, input logic [15:0] h);
    sample_t s;
    s.temp = t;
    s.press = p;
    s.hum = h;
    pending.push_back(s);
  endtask

  task automatic drain();
    while (pending.size() > 0 || holding || readings_due.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: divisor is zero
    add_sample(16'h0000, 16'h0000, 16'h0000);
    add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_sample(16'h8000, 16'h5000, 16'h6000);
    drain();
    write_cal(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    load_cal(48'hFC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D, 64'hC6F8_3C8C_FFF9_008C,
             48'h00_016A_4B_1770, 40'h1E_0032_0139);
    add_sample(16'h0000, 16'h0000, 16'h0000);
    add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_sample(16'h7E00, 16'h5A00, 16'h6600);
    add_sample(16'h8000, 16'h8000, 16'h8000);
    add_sample(16'h7FFF, 16'h0001, 16'hFFFF);
    add_sample(16'h0001, 16'hFFFE, 16'h0000);
    add_sample(16'h5555, 16'hAAAA, 16'h5555);
    add_sample(16'hAAAA, 16'h5555, 16'hAAAA);
    drain();
    // no pressure divisor but live temperature and humidity
    load_cal(48'hFC18_6743_6B70, 64'h0B27_0BD0_D643_0000, 64'hC6F8_3C8C_FFF9_008C,
             48'h00_016A_4B_1770, 40'h1E_0032_0139);
    add_sample(16'h7E00, 16'h5A00, 16'h6600);
    add_sample(16'hFFFF, 16'h0000, 16'hFFFF);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: load_cal(48'hFC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D, 64'hC6F8_3C8C_FFF9_008C,
                    48'h00_016A_4B_1770, 40'h1E_0032_0139);
        1: load_cal('1, '1, '1, '1, '1);
        2: load_cal(48'h8000_8000_0000, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000,
                    48'h00_8000_FF_8000, 40'h80_8000_8000);
        3: load_cal(48'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_7FFF,
                    48'hFF_7FFF_00_7FFF, 40'h7F_7FFF_7FFF);
        default: load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                          {$urandom, $urandom}, 48'({$urandom, $urandom}),
                          40'({$urandom, $urandom}));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 77; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 77; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int i = 0; i < 140; i++) add_sample(rand_raw(), rand_raw(), rand_raw());
      if (ph == 3) begin
        while (pending.size() > 70) @(posedge clk);
        hold_off = 1;
        while (holding || readings_due.size() > 0) @(posedge clk);
        hold_off = 0;
      end
      drain();
    end
    recv_stall_pct = 0;
    repeat (100) @(posedge clk);
    if (errors == 0 && readings_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
